// ===== rtl/pvd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline vertex densifier package
// Shared types and constants: state codes, register indexes and field widths.
// ----------------------------------------------------------------------------
package pvd_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned OrderW   = 16;
  localparam int unsigned SpacingW = 31;
  localparam int unsigned KindW    = 2;
  localparam int unsigned TBits    = 30;
  localparam int unsigned Lanes    = 4;

  localparam logic [1:0] RegDensifyEnable = 2'd0;
  localparam logic [1:0] RegInsertSpacing = 2'd1;
  localparam logic [1:0] RegVertexKind    = 2'd2;
  localparam logic [1:0] RegOrderEnable   = 2'd3;

  localparam logic [KindW-1:0] KindXyz  = 2'd1;
  localparam logic [KindW-1:0] KindXyzm = 2'd2;

  typedef enum logic [9:0] {
    StIdle      = 10'b00_0000_0001,
    StSquare    = 10'b00_0000_0010,
    StRoot      = 10'b00_0000_0100,
    StCount     = 10'b00_0000_1000,
    StDivide    = 10'b00_0001_0000,
    StEmitStart = 10'b00_0010_0000,
    StAccum     = 10'b00_0100_0000,
    StMul       = 10'b00_1000_0000,
    StEmitIns   = 10'b01_0000_0000,
    StEmitEnd   = 10'b10_0000_0000
  } state_e;

endpackage

// ===== rtl/polyline_vertex_densifier_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline vertex densifier
// Copies vertices or inserts points at fixed spacing along each segment,
// with bit-serial squaring, square root, division and interpolation.
// ----------------------------------------------------------------------------
// Copy mode and vertices without a segment skip the arithmetic.
// A segment with N inserted points first finds the length by squaring and root
// and the count, then divides when N > 0, then interpolates each point,
// all in the one-bit-per-cycle shift units; one item is in work at a time.
// Reset clears all control state and the vertex history and loads the
// register defaults; there is no clearing pass.
module polyline_vertex_densifier_unit
  import pvd_pkg::*;
#(
  parameter int unsigned MAX_INSERTED    = 62,
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [30:0]    cfg_data_i,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  // coord_x, coord_y, coord_z, coord_m
  input  logic [127:0]   s_axis_tdata,
  // line_start, part_start
  input  logic [1:0]     s_axis_tuser,
  input  logic           s_axis_tlast,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  // out_x, out_y, out_z, out_m, point_order
  output logic [143:0]   m_axis_tdata,
  // insert_overflow
  output logic           m_axis_tuser,
  output logic           m_axis_tlast
);

  localparam int unsigned CntW = $clog2(MAX_INSERTED + 2);
  localparam longint unsigned SpacingRaw = 64'd100 << COORD_FRAC_BITS;
  localparam logic [SpacingW-1:0] SpacingReset =
    (SpacingRaw > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : SpacingRaw[SpacingW-1:0];
  localparam logic [CntW-1:0] MaxIns = CntW'(MAX_INSERTED);

  state_e state_q, state_d;

  logic                densify_q, densify_d;
  logic [SpacingW-1:0] spacing_q, spacing_d;
  logic [KindW-1:0]    kind_q, kind_d;
  logic                order_en_q, order_en_d;

  logic signed [31:0] cur_q [Lanes];
  logic signed [31:0] cur_d [Lanes];
  logic signed [31:0] prev_q [Lanes];
  logic signed [31:0] prev_d [Lanes];
  logic               have_prev_q, have_prev_d;
  logic               pe_q, pe_d;
  logic [OrderW-1:0]  order_q, order_d;

  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] mx_q, mx_d, my_q, my_d;
  logic [65:0] sx_q, sx_d, sy_q, sy_d;
  logic [65:0] sq_q, sq_d;
  logic [36:0] rem_q, rem_d;
  logic [32:0] root_q, root_d;
  logic [33:0] lc_q, lc_d;
  logic [37:0] kd_q, kd_d;
  logic [CntW-1:0] nins_q, nins_d, kidx_q, kidx_d;
  logic        ovf_q, ovf_d;
  logic [32:0] drem_q, drem_d;
  logic [30:0] dq_q, dq_d;
  logic [32:0] r0_q, r0_d;
  logic [30:0] tq_q, tq_d;
  logic [32:0] tr_q, tr_d;
  logic [30:0] tsh_q, tsh_d;
  logic [32:0] dmag_q [Lanes];
  logic [32:0] dmag_d [Lanes];
  logic        dneg_q [Lanes];
  logic        dneg_d [Lanes];
  logic [63:0] msh_q [Lanes];
  logic [63:0] msh_d [Lanes];
  logic [63:0] macc_q [Lanes];
  logic [63:0] macc_d [Lanes];

  logic          out_valid_q, out_valid_d;
  logic [143:0]  out_data_q, out_data_d;
  logic          out_last_q, out_last_d;
  logic          out_ovf_q, out_ovf_d;

  logic signed [32:0] diff [Lanes];
  logic signed [31:0] ins_pt [Lanes];
  logic signed [31:0] pt [Lanes];
  logic [64:0] rnd [Lanes];
  logic [36:0] rem_t, trial;
  logic [32:0] root_n;
  logic [36:0] rem_n;
  logic [33:0] dv_t;
  logic        dv_bit;
  logic [33:0] sum_r;
  logic [30:0] sum_q;
  logic        can_load, load, pt_last, finish, in_acc, seg, dens;

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign can_load      = !out_valid_q || m_axis_tready;
  assign dens          = densify_q && (spacing_q != '0);
  assign seg           = have_prev_q && !s_axis_tuser[0] && !s_axis_tuser[1];

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      diff[l] = {s_axis_tdata[32*l+31], s_axis_tdata[32*l +: 32]}
              - {prev_q[l][31], prev_q[l]};
      rnd[l]  = {1'b0, macc_q[l]} + 65'(1 << (TBits - 1));
      if (dneg_q[l]) begin
        ins_pt[l] = prev_q[l] - rnd[l][61:30];
      end else begin
        ins_pt[l] = prev_q[l] + rnd[l][61:30];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    densify_d   = densify_q;
    spacing_d   = spacing_q;
    kind_d      = kind_q;
    order_en_d  = order_en_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    pe_d        = pe_q;
    order_d     = order_q;
    cnt_d       = cnt_q;
    mx_d = mx_q; my_d = my_q; sx_d = sx_q; sy_d = sy_q; sq_d = sq_q;
    rem_d = rem_q; root_d = root_q; lc_d = lc_q; kd_d = kd_q;
    nins_d = nins_q; kidx_d = kidx_q; ovf_d = ovf_q;
    drem_d = drem_q; dq_d = dq_q; r0_d = r0_q; tq_d = tq_q; tr_d = tr_q;
    tsh_d = tsh_q;
    dmag_d = dmag_q; dneg_d = dneg_q; msh_d = msh_q; macc_d = macc_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    load    = 1'b0;
    pt_last = 1'b0;
    finish  = 1'b0;
    pt      = cur_q;
    rem_t = '0; trial = '0; root_n = '0; rem_n = '0;
    dv_t = '0; dv_bit = 1'b0; sum_r = '0; sum_q = '0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDensifyEnable: densify_d  = cfg_data_i[0];
        RegInsertSpacing: spacing_d  = cfg_data_i;
        RegVertexKind:    kind_d     = cfg_data_i[KindW-1:0];
        RegOrderEnable:   order_en_d = cfg_data_i[0];
        default: ;
      endcase
    end

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          for (int l = 0; l < Lanes; l++) begin
            cur_d[l]  = s_axis_tdata[32*l +: 32];
            dneg_d[l] = diff[l][32];
            dmag_d[l] = diff[l][32] ? 33'(-diff[l]) : 33'(diff[l]);
          end
          pe_d  = s_axis_tlast;
          ovf_d = 1'b0;
          if (s_axis_tuser[0]) begin
            order_d = '0;
          end
          if (!dens) begin
            state_d = StEmitEnd;
          end else if (seg) begin
            mx_d    = diff[0][32] ? 33'(-diff[0]) : 33'(diff[0]);
            my_d    = diff[1][32] ? 33'(-diff[1]) : 33'(diff[1]);
            sx_d    = {33'd0, mx_d};
            sy_d    = {33'd0, my_d};
            sq_d    = '0;
            cnt_d   = '0;
            state_d = StSquare;
          end else if (s_axis_tlast) begin
            state_d = StEmitEnd;
          end else begin
            for (int l = 0; l < Lanes; l++) begin
              prev_d[l] = s_axis_tdata[32*l +: 32];
            end
            have_prev_d = 1'b1;
          end
        end
      end
      StSquare: begin
        sq_d = sq_q + (mx_q[0] ? sx_q : 66'd0) + (my_q[0] ? sy_q : 66'd0);
        mx_d = mx_q >> 1;
        my_d = my_q >> 1;
        sx_d = sx_q << 1;
        sy_d = sy_q << 1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd32) begin
          cnt_d   = '0;
          rem_d   = '0;
          root_d  = '0;
          state_d = StRoot;
        end
      end
      StRoot: begin
        rem_t = {rem_q[34:0], sq_q[65:64]};
        trial = {2'b00, root_q, 2'b01};
        if (rem_t >= trial) begin
          rem_n  = rem_t - trial;
          root_n = {root_q[31:0], 1'b1};
        end else begin
          rem_n  = rem_t;
          root_n = {root_q[31:0], 1'b0};
        end
        rem_d  = rem_n;
        root_d = root_n;
        sq_d   = sq_q << 2;
        cnt_d  = cnt_q + 6'd1;
        if (cnt_q == 6'd32) begin
          lc_d    = {1'b0, root_n} + {33'd0, (rem_n != '0)};
          kd_d    = {7'd0, spacing_q};
          nins_d  = '0;
          state_d = StCount;
        end
      end
      StCount: begin
        if (kd_q < {4'd0, lc_q} && nins_q != MaxIns) begin
          nins_d = nins_q + CntW'(1);
          kd_d   = kd_q + {7'd0, spacing_q};
        end else begin
          ovf_d = (kd_q < {4'd0, lc_q});
          if (nins_q == '0) begin
            state_d = StEmitStart;
          end else begin
            drem_d  = {3'd0, spacing_q[30:1]};
            dq_d    = '0;
            cnt_d   = '0;
            state_d = StDivide;
          end
        end
      end
      StDivide: begin
        dv_bit = (cnt_q == '0) ? spacing_q[0] : 1'b0;
        dv_t   = {drem_q, dv_bit};
        if (dv_t >= {1'b0, root_q}) begin
          dv_t = dv_t - {1'b0, root_q};
          dq_d = {dq_q[29:0], 1'b1};
        end else begin
          dq_d = {dq_q[29:0], 1'b0};
        end
        drem_d = dv_t[32:0];
        cnt_d  = cnt_q + 6'd1;
        if (cnt_q == 6'd30) begin
          r0_d    = dv_t[32:0];
          tq_d    = '0;
          tr_d    = '0;
          kidx_d  = '0;
          state_d = StEmitStart;
        end
      end
      StEmitStart: begin
        if (can_load) begin
          load    = 1'b1;
          pt      = prev_q;
          pt_last = (nins_q == '0) && !pe_q;
          if (nins_q != '0) begin
            state_d = StAccum;
          end else if (pe_q) begin
            state_d = StEmitEnd;
          end else begin
            finish = 1'b1;
          end
        end
      end
      StAccum: begin
        sum_r = {1'b0, tr_q} + {1'b0, r0_q};
        sum_q = tq_q + dq_q;
        if (sum_r >= {1'b0, root_q}) begin
          sum_r = sum_r - {1'b0, root_q};
          sum_q = sum_q + 31'd1;
        end
        tr_d   = sum_r[32:0];
        tq_d   = sum_q;
        tsh_d  = sum_q;
        kidx_d = kidx_q + CntW'(1);
        for (int l = 0; l < Lanes; l++) begin
          msh_d[l]  = {31'd0, dmag_q[l]};
          macc_d[l] = '0;
        end
        cnt_d   = '0;
        state_d = StMul;
      end
      StMul: begin
        for (int l = 0; l < Lanes; l++) begin
          if (tsh_q[0]) begin
            macc_d[l] = macc_q[l] + msh_q[l];
          end
          msh_d[l] = msh_q[l] << 1;
        end
        tsh_d = tsh_q >> 1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd30) begin
          state_d = StEmitIns;
        end
      end
      StEmitIns: begin
        if (can_load) begin
          load    = 1'b1;
          pt      = ins_pt;
          pt_last = (kidx_q == nins_q) && !pe_q;
          if (kidx_q != nins_q) begin
            state_d = StAccum;
          end else if (pe_q) begin
            state_d = StEmitEnd;
          end else begin
            finish = 1'b1;
          end
        end
      end
      StEmitEnd: begin
        if (can_load) begin
          load    = 1'b1;
          pt      = cur_q;
          pt_last = 1'b1;
          finish  = 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase

    if (load) begin
      out_valid_d = 1'b1;
      out_last_d  = pt_last;
      out_ovf_d   = ovf_q;
      out_data_d[31:0]  = pt[0];
      out_data_d[63:32] = pt[1];
      out_data_d[95:64] = (kind_q == KindXyz || kind_q == KindXyzm) ? pt[2] : 32'd0;
      out_data_d[127:96]  = (kind_q == KindXyzm) ? pt[3] : 32'd0;
      out_data_d[143:128] = order_en_q ? order_q : '0;
      if (order_en_q) begin
        order_d = order_q + 16'd1;
      end
    end

    if (finish) begin
      prev_d      = cur_q;
      have_prev_d = !pe_q;
      state_d     = StIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      densify_q   <= 1'b0;
      spacing_q   <= SpacingReset;
      kind_q      <= '0;
      order_en_q  <= 1'b0;
      have_prev_q <= 1'b0;
      order_q     <= '0;
      out_valid_q <= 1'b0;
      for (int l = 0; l < Lanes; l++) begin
        prev_q[l] <= '0;
      end
    end else begin
      state_q     <= state_d;
      densify_q   <= densify_d;
      spacing_q   <= spacing_d;
      kind_q      <= kind_d;
      order_en_q  <= order_en_d;
      have_prev_q <= have_prev_d;
      order_q     <= order_d;
      out_valid_q <= out_valid_d;
      prev_q      <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    pe_q  <= pe_d;
    cnt_q <= cnt_d;
    mx_q <= mx_d; my_q <= my_d; sx_q <= sx_d; sy_q <= sy_d; sq_q <= sq_d;
    rem_q <= rem_d; root_q <= root_d; lc_q <= lc_d; kd_q <= kd_d;
    nins_q <= nins_d; kidx_q <= kidx_d; ovf_q <= ovf_d;
    drem_q <= drem_d; dq_q <= dq_d; r0_q <= r0_d; tq_q <= tq_d; tr_q <= tr_d;
    tsh_q <= tsh_d;
    dmag_q <= dmag_d; dneg_q <= dneg_d; msh_q <= msh_d; macc_q <= macc_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_ovf_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCount) |-> (nins_q <= MaxIns))
    else $error("inserted point count beyond cap");

  a_frac_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMul) |-> (tq_q <= 31'h4000_0000))
    else $error("interpolation fraction above one");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!out_valid_q || m_axis_tready))
    else $error("result register overwritten while waiting");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && pt_last) |=> (state_q == StIdle))
    else $error("work continues after the last result");

endmodule

// ===== bench/tb_polyline_vertex_densifier_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline vertex densifier testbench
// Streams directed and random polylines through the unit under several
// register settings, predicts every output point in the bench and compares
// each output transaction field by field, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_polyline_vertex_densifier_unit;
  import pvd_pkg::*;

  localparam int MaxIns = 62;
  localparam int SettleCycles = 2600;

  typedef struct packed {
    logic ls, ps, pe;
    logic [31:0] x, y, z, m;
  } vertex_t;

  typedef struct packed {
    logic [31:0] x, y, z, m;
    logic [15:0] order;
    logic        last, ovf;
  } point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [30:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  polyline_vertex_densifier_unit u_dut (.*);

  always #2ns clk_i = ~clk_i;

  vertex_t pending_vertices[$];
  point_t  expected_points[$];
  vertex_t offered;
  int errors = 0, vertices_sent = 0, points_seen = 0, overflow_seen = 0;
  int gap_left = 0, burst_left = 4, long_hold = 0;
  bit hold_armed = 1'b0;

  // Bench copy of the registers and the vertex history.
  logic        de_q = 1'b0;
  logic [30:0] sp_q = 31'd6553600;
  logic [1:0]  vk_q = '0;
  logic        oe_q = 1'b0;
  longint      prev_x = 0, prev_y = 0, prev_z = 0, prev_m = 0;
  bit          have_prev = 1'b0;
  logic [15:0] order_cnt = '0;

  function automatic longint lerp_coord(longint a, longint b, logic [63:0] t);
    longint d;
    logic [127:0] mag, off;
    d = b - a;
    mag = (d < 0) ? 128'(-d) : 128'(d);
    off = (mag * t + (128'd1 << (TBits - 1))) >> TBits;
    return (d < 0) ? a - longint'(off) : a + longint'(off);
  endfunction

  task automatic queue_point(inout point_t res[$], input longint x, y, z, m);
    point_t p;
    p.x = x[31:0];
    p.y = y[31:0];
    p.z = (vk_q == KindXyz || vk_q == KindXyzm) ? z[31:0] : '0;
    p.m = (vk_q == KindXyzm) ? m[31:0] : '0;
    p.order = oe_q ? order_cnt : '0;
    if (oe_q) order_cnt = order_cnt + 16'd1;
    p.last = 1'b0;
    p.ovf = 1'b0;
    res.push_back(p);
  endtask

  task automatic predict_points(vertex_t v);
    point_t res[$];
    longint x, y, z, m, adx, ady;
    logic [127:0] s, kd, c, len;
    logic [63:0] t;
    int cnt;
    bit ovf;
    x = longint'(signed'(v.x));
    y = longint'(signed'(v.y));
    z = longint'(signed'(v.z));
    m = longint'(signed'(v.m));
    ovf = 1'b0;
    if (v.ls) order_cnt = '0;
    if (de_q && sp_q != 0) begin
      if (have_prev && !v.ls && !v.ps) begin
        adx = (x > prev_x) ? x - prev_x : prev_x - x;
        ady = (y > prev_y) ? y - prev_y : prev_y - y;
        s = 128'(adx) * 128'(adx) + 128'(ady) * 128'(ady);
        queue_point(res, prev_x, prev_y, prev_z, prev_m);
        cnt = 0;
        while (cnt < MaxIns) begin
          kd = 128'(cnt + 1) * 128'(sp_q);
          if (!(kd * kd < s)) break;
          cnt++;
        end
        if (cnt == MaxIns) begin
          kd = 128'(MaxIns + 1) * 128'(sp_q);
          ovf = (kd * kd < s);
        end
        len = '0;
        for (int b = 32; b >= 0; b--) begin
          c = len | (128'd1 << b);
          if (!(s < c * c)) len = c;
        end
        for (int k = 1; k <= cnt; k++) begin
          kd = 128'(k) * 128'(sp_q);
          t = (len != 0) ? 64'((kd << TBits) / len) : 64'd0;
          if (t > (64'd1 << TBits)) t = 64'd1 << TBits;
          queue_point(res, lerp_coord(prev_x, x, t), lerp_coord(prev_y, y, t),
                      lerp_coord(prev_z, z, t), lerp_coord(prev_m, m, t));
        end
      end
      if (v.pe) queue_point(res, x, y, z, m);
    end else begin
      queue_point(res, x, y, z, m);
    end
    prev_x = x; prev_y = y; prev_z = z; prev_m = m;
    have_prev = !v.pe;
    foreach (res[i]) begin
      res[i].ovf = ovf;
      if (i == res.size() - 1) res[i].last = 1'b1;
      expected_points.push_back(res[i]);
    end
  endtask

  // Driver: bursts of transactions separated by random gaps.
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      predict_points(offered);
      void'(pending_vertices.pop_front());
      vertices_sent++;
    end
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_vertices.size() > 0) begin
        offered = pending_vertices[0];
        s_axis_tdata <= {offered.m, offered.z, offered.y, offered.x};
        s_axis_tuser <= {offered.ps, offered.ls};
        s_axis_tlast <= offered.pe;
        s_axis_tvalid <= 1'b1;
        if (--burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: checks each output transaction and applies back-pressure.
  always @(posedge clk_i) begin
    point_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
             m_axis_tdata[127:96], m_axis_tdata[143:128], m_axis_tlast, m_axis_tuser};
      points_seen++;
      if (m_axis_tuser) overflow_seen++;
      if (expected_points.size() == 0) begin
        errors++;
        $display("%t unexpected point: actual %h", $realtime, got);
      end else begin
        want = expected_points.pop_front();
        if (got.x !== want.x) begin
          errors++; $display("%t x: expected %h actual %h", $realtime, want.x, got.x);
        end
        if (got.y !== want.y) begin
          errors++; $display("%t y: expected %h actual %h", $realtime, want.y, got.y);
        end
        if (got.z !== want.z) begin
          errors++; $display("%t z: expected %h actual %h", $realtime, want.z, got.z);
        end
        if (got.m !== want.m) begin
          errors++; $display("%t m: expected %h actual %h", $realtime, want.m, got.m);
        end
        if (got.order !== want.order) begin
          errors++;
          $display("%t order: expected %0d actual %0d", $realtime, want.order, got.order);
        end
        if (got.last !== want.last) begin
          errors++;
          $display("%t run_last: expected %b actual %b", $realtime, want.last, got.last);
        end
        if (got.ovf !== want.ovf) begin
          errors++;
          $display("%t overflow: expected %b actual %b", $realtime, want.ovf, got.ovf);
        end
      end
    end
    if (hold_armed && expected_points.size() > 0) begin
      hold_armed = 1'b0;
      long_hold = 4000;
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (long_hold > 0) begin
      long_hold--;
      m_axis_tready <= 1'b0;
    end else if ((vertices_sent / 50) % 3 == 0) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 2) != 0);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegDensifyEnable: de_q = val[0];
      RegInsertSpacing: sp_q = val;
      RegVertexKind:    vk_q = val[1:0];
      RegOrderEnable:   oe_q = val[0];
      default: ;
    endcase
  endtask

  task automatic configure(logic de, logic [30:0] sp, logic [1:0] vk, logic oe);
    write_reg(RegDensifyEnable, 31'(de));
    write_reg(RegInsertSpacing, sp);
    write_reg(RegVertexKind, 31'(vk));
    write_reg(RegOrderEnable, 31'(oe));
  endtask

  task automatic drain();
    while (pending_vertices.size() > 0 || expected_points.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic push_vertex(bit ls, ps, pe, logic [31:0] x, y, z, m);
    vertex_t v;
    v = '{ls: ls, ps: ps, pe: pe, x: x, y: y, z: z, m: m};
    pending_vertices.push_back(v);
  endtask

  function automatic logic [31:0] step_coord(logic [31:0] base);
    longint lim;
    lim = longint'(sp_q) * 5;
    if (lim > 64'h3FFF_FFFF) lim = 64'h3FFF_FFFF;
    if ($urandom_range(0, 1)) return base + 32'($urandom_range(0, 32'(lim)));
    return base - 32'($urandom_range(0, 32'(lim)));
  endfunction

  task automatic random_polylines(int count);
    logic [31:0] x, y, z, m;
    int len;
    while (count > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        push_vertex($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                    $urandom, $urandom, $urandom, $urandom);
        count--;
      end else begin
        len = $urandom_range(1, 6);
        x = $urandom_range(0, 1) ? $urandom : 32'(signed'($urandom_range(0, 2000000)));
        y = $urandom;
        z = $urandom;
        m = $urandom;
        for (int i = 0; i < len; i++) begin
          push_vertex(i == 0, i == 0 || $urandom_range(0, 15) == 0,
                      i == len - 1 || $urandom_range(0, 15) == 0, x, y, z, m);
          x = step_coord(x);
          y = step_coord(y);
          z = $urandom;
          m = $urandom;
        end
        count -= len;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Default registers: copy mode, extreme coordinates.
    push_vertex(1, 1, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, 32'hFFFF_FFFF);
    push_vertex(0, 0, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h8000_0000);
    drain();
    configure(1'b1, 31'd6553600, KindXyzm, 1'b1);
    // Densify: normal, zero length, capped, break without part start.
    push_vertex(1, 1, 0, 32'h0, 32'h0, 32'h0, 32'h0);
    push_vertex(0, 0, 0, 32'h0140_0000, 32'h0, 32'h0064_0000, 32'hFF9C_0000);
    push_vertex(0, 0, 0, 32'h0140_0000, 32'h0, 32'h5, 32'h6);
    push_vertex(0, 0, 0, 32'hFEC0_0000, 32'h00F0_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    push_vertex(0, 0, 1, 32'hFEC0_0000, 32'hFE00_0000, 32'h1, 32'h2);
    push_vertex(0, 0, 0, 32'h1000, 32'h2000, 32'h3, 32'h4);
    push_vertex(0, 0, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h3, 32'h4);
    push_vertex(1, 1, 1, 32'h55, 32'h66, 32'h77, 32'h88);
    push_vertex(0, 1, 0, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
    push_vertex(0, 0, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    drain();
    configure(1'b1, 31'h7FFF_FFFF, KindXyz, 1'b1);
    push_vertex(1, 1, 0, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
    push_vertex(0, 0, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
    drain();
    configure(1'b1, 31'd0, 2'd3, 1'b0);
    random_polylines(8);
    drain();
    configure(1'b1, 31'd1, KindXyzm, 1'b1);
    push_vertex(1, 1, 0, 32'h0, 32'h0, 32'h0, 32'h0);
    push_vertex(0, 0, 1, 32'd40, 32'd9, 32'd1000, 32'hFFFF_F000);
    drain();
    // Random phases under several settings.
    configure(1'b1, 31'd6553600, KindXyzm, 1'b1);
    hold_armed = 1'b1;
    random_polylines(90);
    drain();
    configure(1'b0, 31'd6553600, KindXyz, 1'b1);
    random_polylines(70);
    drain();
    configure(1'b1, 31'($urandom_range(1, 32'h0100_0000)), KindXyz, 1'b0);
    random_polylines(80);
    drain();
    configure(1'b1, 31'($urandom_range(32'h0100_0000, 32'h7FFF_FFFF)), 2'd0, 1'b1);
    random_polylines(70);
    drain();
    configure(1'b1, 31'($urandom_range(1, 32'h0010_0000)), KindXyzm, 1'b1);
    random_polylines(90);
    drain();
    configure(1'b1, 31'h7FFF_FFFF, 2'd3, 1'b0);
    random_polylines(40);
    drain();
    $display("Sent %0d vertices and checked %0d points, %0d of them flagged as capped.",
             vertices_sent, points_seen, overflow_seen);
    $display("Settings covered copy and densify modes, all vertex kinds and spacings.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
